[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They are compiled out when
// NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/cbts_pkg.sv]
// ---------------------------------------------------------------------------
// CAN bit timing search package
// Constants and types shared by the front end, the search engine and the
// divider.
// ---------------------------------------------------------------------------
package cbts_pkg;

	localparam int SEG1_MAX     = 15;
	localparam int SEG2_MAX     = 7;
	localparam int PRESCALE_MAX = 64;
	localparam int ERR_BOUND    = 4095;

	// Half segment counts run from 2 (count 4) up to the last odd count.
	localparam int B_FIRST = 2;
	localparam int B_LAST  = SEG1_MAX + SEG2_MAX + 2;

	localparam int CLK_W  = 26;
	localparam int DIV_W  = 25;
	localparam int RATE_W = 20;
	localparam int B_W    = 5;
	localparam int ERR_W  = 12;

	localparam logic [CLK_W-1:0] CLOCK_RESET = 26'd16000000;

	// Reciprocal of 100 scaled by 2^19, exact for the products seen here.
	localparam logic [12:0] RECIP_100 = 13'd5243;

	// One request as held in the queue.
	typedef struct packed {
		logic [RATE_W-1:0] bit_rate;
		logic [1:0]        jump_width;
		logic [6:0]        sample_point_pct;
		logic              triple_sample;
		logic              rate_zero;
	} item_t;

	// Queue head status toward the search engine.
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/cbts_front.sv]
// ---------------------------------------------------------------------------
// Request front end
// Accepts request words, flags a zero bit rate and holds them in a
// two-entry queue ahead of the search engine.
// ---------------------------------------------------------------------------
module cbts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,
	input  logic                 pop,
	output cbts_pkg::head_t      head
);

	cbts_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	cbts_pkg::item_t in_item;
	logic            push;
	logic            do_pop;

	// Unpack and classify the incoming word.
	always_comb begin
		in_item.bit_rate         = s_tdata[19:0];
		in_item.jump_width       = s_tdata[21:20];
		in_item.sample_point_pct = s_tdata[28:22];
		in_item.triple_sample    = s_tdata[29];
		in_item.rate_zero        = (s_tdata[19:0] == 20'd0);
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && (count_q != 2'd0);

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

endmodule

[hw/rtl/cbts_div.sv]
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cbts_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbts_pkg::div_req_t   req,
	output cbts_pkg::div_rsp_t   rsp
);

	logic [cbts_pkg::DIV_W-1:0] dvd_q;
	logic [cbts_pkg::DIV_W-1:0] dsr_q;
	logic [cbts_pkg::DIV_W-1:0] rem_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [cbts_pkg::DIV_W:0]   r_next;
	logic [cbts_pkg::DIV_W:0]   diff;
	logic                       ge;

	// One trial subtraction.
	always_comb begin
		r_next = {rem_q, dvd_q[cbts_pkg::DIV_W-1]};
		diff   = r_next - {1'b0, dsr_q};
		ge     = (r_next >= {1'b0, dsr_q});
	end

	// Datapath; the dividend register fills with quotient bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cbts_pkg::DIV_W-1:0] : r_next[cbts_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[cbts_pkg::DIV_W-2:0], ge};
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 5'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= 5'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(cbts_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[hw/rtl/cbts_search.sv]
// ---------------------------------------------------------------------------
// Bit timing search engine
// Walks the segment counts with a shared divider, keeps the best prescaler,
// splits the segments and holds the result word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbts_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cbts_pkg::CLK_W-1:0]    clock_hz,
	input  cbts_pkg::head_t               head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	output logic                          m_tuser
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_D1GO  = 4'd1;
	localparam logic [3:0] ST_D1    = 4'd2;
	localparam logic [3:0] ST_PSEL  = 4'd3;
	localparam logic [3:0] ST_D2GO  = 4'd4;
	localparam logic [3:0] ST_D2    = 4'd5;
	localparam logic [3:0] ST_NEXT  = 4'd6;
	localparam logic [3:0] ST_FIN1  = 4'd7;
	localparam logic [3:0] ST_FIN2  = 4'd8;

	logic [3:0]                     st_q;
	cbts_pkg::item_t                item_q;
	logic [cbts_pkg::B_W-1:0]       b_q;
	logic                           odd_q;
	logic [cbts_pkg::DIV_W-1:0]     pe_q;
	logic [6:0]                     p_q;
	logic [cbts_pkg::ERR_W-1:0]     best_err_q;
	logic [cbts_pkg::B_W-1:0]       best_b_q;
	logic [5:0]                     best_p_q;
	logic                           found_q;
	logic [11:0]                    prod_q;
	logic                           out_valid_q;
	logic [7:0]                     byte0_q;
	logic [7:0]                     byte1_q;
	logic                           ok_q;

	cbts_pkg::div_req_t             div_req;
	cbts_pkg::div_rsp_t             div_rsp;
	logic [cbts_pkg::B_W-1:0]       q;
	logic [cbts_pkg::DIV_W:0]       p_full;
	logic [cbts_pkg::DIV_W-1:0]     err;
	logic [24:0]                    recip;
	logic [5:0]                     dq;
	logic signed [6:0]              seg2_raw;
	logic signed [6:0]              seg2_c;
	logic signed [6:0]              seg1_r;
	logic signed [6:0]              seg1_f;
	logic signed [6:0]              seg2_f;
	logic [15:0]                    err_x10;
	logic                           fail;
	logic                           fin_go;

	cbts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Divider operands and candidate arithmetic.
	always_comb begin
		q                = b_q + 5'd1;
		div_req.dividend = clock_hz[cbts_pkg::CLK_W-1:1];
		div_req.start    = (st_q == ST_D1GO) || (st_q == ST_D2GO);
		if (st_q == ST_D1GO) begin
			div_req.divisor = 25'(q) * 25'(item_q.bit_rate);
		end else begin
			div_req.divisor = 25'(p_q) * 25'(q);
		end
		p_full = {1'b0, pe_q} + 26'(odd_q);
		if (div_rsp.quotient > 25'(item_q.bit_rate)) begin
			err = div_rsp.quotient - 25'(item_q.bit_rate);
		end else begin
			err = 25'(item_q.bit_rate) - div_rsp.quotient;
		end
	end

	// Segment split and the final acceptance test.
	always_comb begin
		recip    = 25'(prod_q) * 25'(cbts_pkg::RECIP_100);
		dq       = recip[24:19];
		seg2_raw = $signed({2'b00, best_b_q}) - $signed({1'b0, dq});
		if (seg2_raw < 7'sd0) begin
			seg2_c = 7'sd0;
		end else if (seg2_raw > 7'(cbts_pkg::SEG2_MAX)) begin
			seg2_c = 7'(cbts_pkg::SEG2_MAX);
		end else begin
			seg2_c = seg2_raw;
		end
		seg1_r = $signed({2'b00, best_b_q}) - seg2_c - 7'sd2;
		if (seg1_r > 7'(cbts_pkg::SEG1_MAX)) begin
			seg1_f = 7'(cbts_pkg::SEG1_MAX);
			seg2_f = $signed({2'b00, best_b_q}) - 7'(cbts_pkg::SEG1_MAX) - 7'sd2;
		end else begin
			seg1_f = seg1_r;
			seg2_f = seg2_c;
		end
		err_x10 = 16'(best_err_q) * 16'd10;
		fail    = !found_q
			|| ((best_err_q != '0) && ({12'd0, item_q.bit_rate} < {16'd0, err_x10}))
			|| (seg1_f < 7'sd0) || (seg2_f < 7'sd0);
	end

	// A search may run while the previous result word waits; it only
	// holds at the end until the result register is free.
	assign pop    = (st_q == ST_IDLE) && head.valid;
	assign fin_go = (st_q == ST_FIN2) && (!out_valid_q || m_tready);

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						st_q <= head.item.rate_zero ? ST_FIN1 : ST_D1GO;
					end
				end
				ST_D1GO: st_q <= ST_D1;
				ST_D1: begin
					if (div_rsp.done) begin
						st_q <= ST_PSEL;
					end
				end
				ST_PSEL: begin
					if ((p_full == '0) || (p_full > 26'(cbts_pkg::PRESCALE_MAX))) begin
						st_q <= ST_NEXT;
					end else begin
						st_q <= ST_D2GO;
					end
				end
				ST_D2GO: st_q <= ST_D2;
				ST_D2: begin
					if (div_rsp.done) begin
						st_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (!odd_q) begin
						st_q <= ST_PSEL;
					end else if (b_q == 5'(cbts_pkg::B_LAST)) begin
						st_q <= ST_FIN1;
					end else begin
						st_q <= ST_D1GO;
					end
				end
				ST_FIN1: st_q <= ST_FIN2;
				ST_FIN2: begin
					if (fin_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (pop) begin
					item_q     <= head.item;
					b_q        <= 5'(cbts_pkg::B_FIRST);
					best_err_q <= 12'(cbts_pkg::ERR_BOUND);
					best_b_q   <= '0;
					best_p_q   <= '0;
				end
			end
			ST_D1: begin
				if (div_rsp.done) begin
					pe_q  <= div_rsp.quotient;
					odd_q <= 1'b0;
				end
			end
			ST_PSEL: p_q <= p_full[6:0];
			ST_D2: begin
				if (div_rsp.done && (err <= {13'd0, best_err_q})) begin
					best_err_q <= err[cbts_pkg::ERR_W-1:0];
					best_b_q   <= b_q;
					best_p_q   <= 6'(p_q - 7'd1);
				end
			end
			ST_NEXT: begin
				if (!odd_q) begin
					odd_q <= 1'b1;
				end else begin
					b_q <= b_q + 5'd1;
				end
			end
			ST_FIN1: prod_q <= 12'(item_q.sample_point_pct) * 12'(best_b_q + 5'd1);
			default: begin
			end
		endcase
	end

	// Candidate found flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (pop) begin
			found_q <= 1'b0;
		end else if ((st_q == ST_D2) && div_rsp.done && (err <= {13'd0, best_err_q})) begin
			found_q <= 1'b1;
		end
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (fail) begin
				byte0_q <= 8'd0;
				byte1_q <= 8'd0;
				ok_q    <= 1'b0;
			end else begin
				byte0_q <= {item_q.jump_width, best_p_q};
				byte1_q <= {item_q.triple_sample, seg2_f[2:0], seg1_f[3:0]};
				ok_q    <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {byte1_q, byte0_q};
	assign m_tuser  = ok_q;

	`ASSERT_SAME(a_div_idle_on_start, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped")
	`ASSERT_SAME(a_p_range, (st_q == ST_D2), (p_q != 7'd0) && (p_q <= 7'd64), "prescaler out of range")
	`ASSERT_SAME(a_fail_zero, m_tvalid && !m_tuser, m_tdata == 16'd0, "failed result not cleared")
	`ASSERT_NEXT(a_fin_fills, fin_go, out_valid_q, "result not registered")

endmodule

[hw/rtl/can_bit_timing_search_top.sv]
// Each request word runs the shared divider once per half segment count and once
// per valid prescaler. A zero bit rate skips the divider.
// A zero bit rate goes from idle straight to the final states. Throughput is one word per search.
// The queue takes two more words while a search runs or a result waits.
// Reset (arst_n, asynchronous, active low) empties the queue and the result
// register and sets clock_hz to 16000000.
// ---------------------------------------------------------------------------
// CAN bit timing search top level
// Front end queue, search engine and the oscillator frequency register.
// ---------------------------------------------------------------------------
module can_bit_timing_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [25:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bit_rate[19:0], jump_width[21:20], sample_point_pct[28:22], triple_sample[29]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// timing_byte0[7:0], timing_byte1[15:8]
	output logic [15:0] m_tdata,
	// ok[0]
	output logic        m_tuser
);

	logic [cbts_pkg::CLK_W-1:0] clock_q;
	cbts_pkg::head_t            head;
	logic                       pop;

	// Oscillator frequency register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= cbts_pkg::CLOCK_RESET;
		end else if (cfg_we) begin
			clock_q <= cfg_wdata;
		end
	end

	cbts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.pop      (pop),
		.head     (head)
	);

	cbts_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.clock_hz (clock_q),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[dv/can_bit_timing_search_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CAN bit timing search checker
// Watches the request and result streams and the clock register port. For
// every accepted request word it works out the expected timing bytes and
// ok flag, queues them, and compares each accepted result word with the
// oldest waiting entry.
// ---------------------------------------------------------------------------
module can_bit_timing_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [25:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          ok_seen
);

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       ok;
	} timing_t;

	timing_t   timing_q[$];
	logic [25:0] osc_hz;

	// Timing search for one request.
	function automatic timing_t search_timing(logic [31:0] word, logic [25:0] osc);
		longint unsigned rate, half_clk, best_err, best_p, q, p, got, err, spt;
		longint best_b, seg1, seg2;
		bit found;
		timing_t r;
		rate = word[19:0];
		spt = word[28:22];
		half_clk = osc / 2;
		best_err = cbts_pkg::ERR_BOUND;
		best_b = 0;
		best_p = 0;
		found = 0;
		r = '0;
		if (rate == 0)
			return r;
		for (int t = 4; t <= (cbts_pkg::SEG2_MAX + cbts_pkg::SEG1_MAX + 2) * 2 + 1; t++) begin
			q = 1 + t / 2;
			p = half_clk / (q * rate) + (t & 1);
			if (p == 0 || p > cbts_pkg::PRESCALE_MAX)
				continue;
			got = half_clk / (p * q);
			err = (got > rate) ? got - rate : rate - got;
			if (err <= best_err) begin
				best_err = err;
				best_b = t / 2;
				best_p = p - 1;
				found = 1;
			end
		end
		if (!found)
			return r;
		if (best_err != 0 && rate / best_err < 10)
			return r;
		seg2 = best_b - (longint'(spt) * (best_b + 1)) / 100;
		if (seg2 < 0)
			seg2 = 0;
		if (seg2 > cbts_pkg::SEG2_MAX)
			seg2 = cbts_pkg::SEG2_MAX;
		seg1 = best_b - seg2 - 2;
		if (seg1 > cbts_pkg::SEG1_MAX) begin
			seg1 = cbts_pkg::SEG1_MAX;
			seg2 = best_b - seg1 - 2;
		end
		if (seg1 < 0 || seg2 < 0)
			return r;
		r.byte0 = {word[21:20], best_p[5:0]};
		r.byte1 = {word[29], seg2[2:0], seg1[3:0]};
		r.ok = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// Register shadow, request prediction and result comparison.
	always @(posedge clk or negedge arst_n) begin
		timing_t want;
		if (!arst_n) begin
			osc_hz = cbts_pkg::CLOCK_RESET;
			timing_q.delete();
			errors = 0;
			results_seen = 0;
			ok_seen = 0;
		end else begin
			if (s_tvalid && s_tready)
				timing_q.push_back(search_timing(s_tdata, osc_hz));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (timing_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result word %h", m_tdata));
				end else begin
					want = timing_q.pop_front();
					ok_seen += want.ok;
					if (m_tdata[7:0] !== want.byte0)
						report_mismatch($sformatf("timing_byte0 %h, expected %h",
							m_tdata[7:0], want.byte0));
					if (m_tdata[15:8] !== want.byte1)
						report_mismatch($sformatf("timing_byte1 %h, expected %h",
							m_tdata[15:8], want.byte1));
					if (m_tuser !== want.ok)
						report_mismatch($sformatf("ok %b, expected %b", m_tuser, want.ok));
				end
			end
			if (cfg_we)
				osc_hz = cfg_wdata;
		end
		pending = timing_q.size();
	end

endmodule

[dv/can_bit_timing_search_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CAN bit timing search testbench
// Sends directed and random bit timing requests under several oscillator
// frequencies, with random gaps on both streams, a long result stall and a
// drain pause. The checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module can_bit_timing_search_top_tb;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 2500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [25:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	int          errors, pending, results_seen, ok_seen;
	int          requests_sent = 0;
	int          idle_cycles = 0;
	bit          hold_results = 0;
	bit          stim_done = 0;

	can_bit_timing_search_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	can_bit_timing_search_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending), .results_seen(results_seen), .ok_seen(ok_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one request word after a random gap. With no gap the valid stays
	// high from the previous word, so words follow back to back.
	task automatic send_request(logic [19:0] rate, logic [1:0] sjw, logic [6:0] spt,
		logic trip);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, trip, spt, sjw, rate};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop the request valid at the end of a burst.
	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until all results are in and the block has gone quiet.
	task automatic drain_and_settle();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_clock(logic [25:0] hz);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly realistic requests: common rates near reachable values.
	task automatic send_random();
		logic [19:0] rate;
		logic [6:0] spt;
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: rate = 20'($urandom);
			1: rate = 20'd0;
			2, 3: rate = 20'($urandom_range(1000, 1000000));
			default: begin
				rate = $urandom_range(0, 5) == 0 ? 20'd1000000
					: 20'(10000 * $urandom_range(1, 100));
				rate = 20'(rate + $urandom_range(0, 200) - 100);
			end
		endcase
		spt = $urandom_range(0, 7) == 0 ? 7'($urandom) : 7'($urandom_range(50, 90));
		send_request(rate, 2'($urandom), spt, 1'($urandom));
	endtask

	// Result side: random stalls, or a long hold-off on request.
	always @(negedge clk) begin
		if (hold_results || $urandom_range(0, 2) == 0)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	// Watchdog: count cycles with nothing accepted.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
			$display("Watchdog expired with %0d results outstanding", pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [25:0] clocks[5];
		clocks = '{26'd1, 26'd50000000, 26'd8000000, 26'd24000000, 26'd33554431};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at the reset frequency.
		send_request(20'd0, 2'd3, 7'd75, 1'b1);
		send_request(20'd1000000, 2'd0, 7'd0, 1'b0);
		send_request(20'd500000, 2'd3, 7'd87, 1'b1);
		send_request(20'd125000, 2'd1, 7'd100, 1'b0);
		send_request(20'd250000, 2'd2, 7'd127, 1'b1);
		send_request(20'd1, 2'd0, 7'd50, 1'b0);
		send_request(20'hFFFFF, 2'd3, 7'd75, 1'b1);
		send_request(20'd10000, 2'd1, 7'd1, 1'b0);
		send_request(20'd900000, 2'd2, 7'd80, 1'b1);
		send_request(20'd333333, 2'd0, 7'd60, 1'b0);
		send_request(20'd50000, 2'd3, 7'd10, 1'b1);
		send_request(20'd20000, 2'd2, 7'd95, 1'b0);

		// Long result stall while requests keep coming.
		fork
			begin
				hold_results = 1;
				repeat (6000) @(negedge clk);
				hold_results = 0;
			end
			begin
				repeat (6) send_random();
				end_burst();
			end
		join

		// Random phases across several frequencies.
		for (int ph = 0; ph < 5; ph++) begin
			write_clock(ph == 4 ? 26'($urandom_range(1, 50000000)) : clocks[ph]);
			if (ph == 0)
				repeat (8) send_random();
			else
				repeat (110) send_random();
			end_burst();
			// Pause the sender until every result is back.
			while (pending != 0) @(negedge clk);
		end
		write_clock(26'd16000000);
		repeat (40) send_random();
		end_burst();

		drain_and_settle();
		stim_done = 1;
		$display("Sent %0d requests over six clock settings; %0d results, %0d with ok set.",
			requests_sent, results_seen, ok_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cbts_pkg.sv
hw/rtl/cbts_front.sv
hw/rtl/cbts_div.sv
hw/rtl/cbts_search.sv
hw/rtl/can_bit_timing_search_top.sv
dv/can_bit_timing_search_checker.sv
dv/can_bit_timing_search_top_tb.sv
